// ===== hw/rtl/ovb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovb_pkg
// Shared types, register indexes and defaults for the overlay pixel blend.
// ----------------------------------------------------------------------------
package ovb_pkg;

  localparam int unsigned FrameWidthDef  = 1920;
  localparam int unsigned FrameHeightDef = 1080;

  localparam int unsigned NumLanes = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegBlendMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGlobalAlpha   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAnchorX       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAnchorY       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOverlayWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOverlayHeight = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCenterAnchor  = 3'd6;

  localparam logic ModeAlpha = 1'b0;
  localparam logic ModeAdd   = 1'b1;

  typedef struct packed {
    logic        blend_mode;
    logic [7:0]  global_alpha;
    logic [11:0] anchor_x;
    logic [11:0] anchor_y;
    logic [12:0] overlay_width;
    logic [12:0] overlay_height;
    logic        center_anchor;
  } cfg_t;

  typedef struct packed {
    logic        en;
    logic [11:0] sx;
    logic [14:0] ex;
    logic [11:0] sy;
    logic [14:0] ey;
  } win_t;

  typedef struct packed {
    logic mode;
    logic cov;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ovb_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovb_window
// Places the overlay window on both axes from the configuration registers.
// ----------------------------------------------------------------------------
module ovb_window #(
  parameter int unsigned FRAME_WIDTH  = ovb_pkg::FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = ovb_pkg::FrameHeightDef
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  ovb_pkg::cfg_t cfg_i,
  output ovb_pkg::win_t win_o
);
  import ovb_pkg::*;

  localparam logic [13:0] LimX = 14'(FRAME_WIDTH);
  localparam logic [13:0] LimY = 14'(FRAME_HEIGHT);

  win_t win_d, win_q;

  logic        okx, oky;
  logic [11:0] sx, sy;
  logic [14:0] ex, ey;

  function automatic logic [12:0] place_start(input logic [11:0] a, input logic [12:0] s,
                                              input logic ctr);
    logic signed [14:0] s2;
    s2 = $signed({2'b00, a, 1'b0}) - $signed({2'b00, s});
    if (!ctr) begin
      place_start = {1'b1, a};
    end else if (s2 < -15'sd1) begin
      place_start = '0;
    end else if (s2[14]) begin
      place_start = {1'b1, 12'd0};
    end else begin
      place_start = {1'b1, s2[12:1]};
    end
  endfunction

  function automatic logic [13:0] place_end(input logic [11:0] a, input logic [12:0] s,
                                            input logic ctr);
    logic [14:0] sum2;
    sum2 = {2'b00, a, 1'b0} + {2'b00, s};
    if (ctr) begin
      place_end = sum2[14:1];
    end else begin
      place_end = {2'b00, a} + {1'b0, s};
    end
  endfunction

  always_comb begin
    logic [12:0] stx, sty;
    logic [13:0] enx, eny;
    stx = place_start(cfg_i.anchor_x, cfg_i.overlay_width, cfg_i.center_anchor);
    sty = place_start(cfg_i.anchor_y, cfg_i.overlay_height, cfg_i.center_anchor);
    enx = place_end(cfg_i.anchor_x, cfg_i.overlay_width, cfg_i.center_anchor);
    eny = place_end(cfg_i.anchor_y, cfg_i.overlay_height, cfg_i.center_anchor);
    okx = stx[12] && (enx <= LimX);
    oky = sty[12] && (eny <= LimY);
    sx  = stx[11:0];
    sy  = sty[11:0];
    ex  = {3'b000, sx} + {2'b00, cfg_i.overlay_width};
    ey  = {3'b000, sy} + {2'b00, cfg_i.overlay_height};
    win_d.en = okx && oky && !(cfg_i.blend_mode == ModeAdd && cfg_i.global_alpha == 8'd0);
    win_d.sx = sx;
    win_d.ex = ex;
    win_d.sy = sy;
    win_d.ey = ey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ovb_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovb_lane
// One colour channel: weighted product, then divide by 255 and mix.
// ----------------------------------------------------------------------------
module ovb_lane (
  input  wire                clk_i,
  input  wire                en_i,
  input  wire                mode_i,
  input  wire  [7:0]         bg_i,
  input  wire  [7:0]         fg_i,
  input  wire  [7:0]         alpha_i,
  input  wire  [7:0]         galpha_i,
  input  ovb_pkg::lane_ctl_t ctl_i,
  output logic [7:0]         res_o
);
  import ovb_pkg::*;

  logic [15:0] num_d, num_q;
  logic [7:0]  bg_q;
  logic        fzero_q;
  logic [15:0] qt;
  logic [8:0]  sum;

  always_comb begin
    if (mode_i == ModeAdd) begin
      num_d = {8'd0, fg_i} * {8'd0, galpha_i};
    end else begin
      num_d = ({8'd0, bg_i} * {8'd0, 8'd255 - alpha_i}) + ({8'd0, fg_i} * {8'd0, alpha_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      bg_q    <= bg_i;
      fzero_q <= (fg_i == 8'd0);
    end
  end

  assign qt  = (num_q + 16'(num_q[15:8]) + 16'd1) >> 8;
  assign sum = {1'b0, bg_q} + {1'b0, qt[7:0]};

  always_comb begin
    if (!ctl_i.cov) begin
      res_o = bg_q;
    end else if (ctl_i.mode == ModeAlpha) begin
      res_o = qt[7:0];
    end else if (fzero_q) begin
      res_o = bg_q;
    end else begin
      res_o = sum[8] ? 8'hFF : sum[7:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/overlay_pixel_blend.sv =====
// Overlay pixel blend: one pixel item per clock while intake is open and the output
// is taken, through the product register in each channel lane, then the output
// register. Window placement is registered from the configuration registers, so
// intake closes after reset and after each register write until the window register
// is updated. Otherwise throughput is set by the output handshake alone.
`default_nettype none
// ----------------------------------------------------------------------------
// overlay_pixel_blend
// Alpha or additive overlay compositing on an RGB pixel stream.
// ----------------------------------------------------------------------------
module overlay_pixel_blend #(
  parameter int unsigned FRAME_WIDTH  = ovb_pkg::FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = ovb_pkg::FrameHeightDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [ovb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [ovb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [11:0]                  pix_x_i,
  input  wire  [11:0]                  pix_y_i,
  input  wire  [7:0]                   bg_c0_i,
  input  wire  [7:0]                   bg_c1_i,
  input  wire  [7:0]                   bg_c2_i,
  input  wire  [7:0]                   fg_c0_i,
  input  wire  [7:0]                   fg_c1_i,
  input  wire  [7:0]                   fg_c2_i,
  input  wire  [7:0]                   fg_alpha_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [7:0]                   out_c0_o,
  output logic [7:0]                   out_c1_o,
  output logic [7:0]                   out_c2_o,
  output logic                         covered_o
);
  import ovb_pkg::*;

  cfg_t      cfg_q;
  win_t      win;
  lane_ctl_t ctl_d, ctl_q;
  logic      s1_valid_q, out_valid_q;
  logic      cfg_pend_q;
  logic      out_en, s1_en;
  logic [7:0] res [NumLanes];
  logic [7:0] bg  [NumLanes];
  logic [7:0] fg  [NumLanes];
  logic [7:0] out_c_q [NumLanes];
  logic       cov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_mode     <= ModeAlpha;
      cfg_q.global_alpha   <= '0;
      cfg_q.anchor_x       <= '0;
      cfg_q.anchor_y       <= '0;
      cfg_q.overlay_width  <= 13'd1;
      cfg_q.overlay_height <= 13'd1;
      cfg_q.center_anchor  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBlendMode:     cfg_q.blend_mode     <= cfg_wdata_i[0];
        RegGlobalAlpha:   cfg_q.global_alpha   <= cfg_wdata_i[7:0];
        RegAnchorX:       cfg_q.anchor_x       <= cfg_wdata_i[11:0];
        RegAnchorY:       cfg_q.anchor_y       <= cfg_wdata_i[11:0];
        RegOverlayWidth:  cfg_q.overlay_width  <= cfg_wdata_i[12:0];
        RegOverlayHeight: cfg_q.overlay_height <= cfg_wdata_i[12:0];
        RegCenterAnchor:  cfg_q.center_anchor  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // hold intake while the window register catches up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pend_q <= 1'b1;
    end else begin
      cfg_pend_q <= cfg_we_i;
    end
  end

  ovb_window #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .win_o (win)
  );

  assign out_en     = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_ready_o = s1_en && !cfg_pend_q;

  assign ctl_d.mode = cfg_q.blend_mode;
  assign ctl_d.cov  = win.en
                   && (pix_x_i >= win.sx) && ({3'b000, pix_x_i} < win.ex)
                   && (pix_y_i >= win.sy) && ({3'b000, pix_y_i} < win.ey);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i && !cfg_pend_q;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      ctl_q <= ctl_d;
    end
  end

  assign bg[0] = bg_c0_i;
  assign bg[1] = bg_c1_i;
  assign bg[2] = bg_c2_i;
  assign fg[0] = fg_c0_i;
  assign fg[1] = fg_c1_i;
  assign fg[2] = fg_c2_i;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    ovb_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (s1_en),
      .mode_i  (cfg_q.blend_mode),
      .bg_i    (bg[l]),
      .fg_i    (fg[l]),
      .alpha_i (fg_alpha_i),
      .galpha_i(cfg_q.global_alpha),
      .ctl_i   (ctl_q),
      .res_o   (res[l])
    );
  end

  // merge lanes into the output item
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      for (int l = 0; l < NumLanes; l++) begin
        out_c_q[l] <= res[l];
      end
      cov_q <= ctl_q.cov;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_c0_o    = out_c_q[0];
  assign out_c1_o    = out_c_q[1];
  assign out_c2_o    = out_c_q[2];
  assign covered_o   = cov_q;

`ifndef SYNTH
  a_empty_out_opens_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !cfg_pend_q |-> in_ready_o)
    else $error("intake closed with empty output register");

  a_s1_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_en |=> out_valid_q)
    else $error("item lost between product stage and output");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_en |=> s1_valid_q)
    else $error("stalled item dropped from product stage");
`endif

endmodule
`default_nettype wire
